/* hw/rtl/dsrl_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_pkg
// Shared widths, register map, reset values and fixed-point helpers for the
// drive slew-rate limiter.
// ----------------------------------------------------------------------------
package dsrl_pkg;

  localparam int FRAC_BITS = 14;
  localparam int DATA_W    = 16;   // command, state and drive width
  localparam int REG_W     = 15;   // configuration register width
  localparam int CALC_W    = 18;   // headroom for step and mix sums
  localparam int APB_DW    = 32;
  localparam int APB_AW    = 5;

  localparam logic signed [CALC_W-1:0] ONE_Q = CALC_W'(64'sd1 << FRAC_BITS);

  typedef enum logic [2:0] {
    REG_DEADBAND    = 3'd0,
    REG_SPEED_ACCEL = 3'd1,
    REG_SPEED_DECEL = 3'd2,
    REG_TURN_ACCEL  = 3'd3,
    REG_TURN_DECEL  = 3'd4
  } reg_idx_t;

  localparam logic [REG_W-1:0] DEADBAND_RST    = REG_W'(164);
  localparam logic [REG_W-1:0] SPEED_ACCEL_RST = REG_W'(82);
  localparam logic [REG_W-1:0] SPEED_DECEL_RST = REG_W'(1638);
  localparam logic [REG_W-1:0] TURN_ACCEL_RST  = REG_W'(49);
  localparam logic [REG_W-1:0] TURN_DECEL_RST  = REG_W'(1638);

  typedef struct packed {
    logic [REG_W-1:0] deadband;
    logic [REG_W-1:0] speed_accel_step;
    logic [REG_W-1:0] speed_decel_step;
    logic [REG_W-1:0] turn_accel_step;
    logic [REG_W-1:0] turn_decel_step;
  } cfg_t;

  function automatic logic signed [CALC_W-1:0] sat_one(input logic signed [CALC_W-1:0] v);
    logic signed [CALC_W-1:0] r;
    if (v > ONE_Q) begin
      r = ONE_Q;
    end else if (v < -ONE_Q) begin
      r = -ONE_Q;
    end else begin
      r = v;
    end
    return r;
  endfunction

  function automatic logic signed [CALC_W-1:0] widen(input logic signed [DATA_W-1:0] v);
    return CALC_W'(v);
  endfunction

endpackage

`default_nettype wire

/* hw/rtl/dsrl_regs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_regs
// APB register file holding the deadband and the four slew steps.
// ----------------------------------------------------------------------------
module dsrl_regs
  import dsrl_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              psel,
  input  wire logic              penable,
  input  wire logic              pwrite,
  input  wire logic [APB_AW-1:0] paddr,
  input  wire logic [APB_DW-1:0] pwdata,
  output logic      [APB_DW-1:0] prdata,
  output logic                   pready,
  output cfg_t                   cfg
);

  cfg_t     cfg_r;
  cfg_t     cfg_nxt;
  reg_idx_t idx;
  logic     wr_en;

  assign idx    = reg_idx_t'(paddr[4:2]);
  assign wr_en  = psel && penable && pwrite && pready;
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      unique case (idx)
        REG_DEADBAND:    cfg_nxt.deadband         = pwdata[REG_W-1:0];
        REG_SPEED_ACCEL: cfg_nxt.speed_accel_step = pwdata[REG_W-1:0];
        REG_SPEED_DECEL: cfg_nxt.speed_decel_step = pwdata[REG_W-1:0];
        REG_TURN_ACCEL:  cfg_nxt.turn_accel_step  = pwdata[REG_W-1:0];
        REG_TURN_DECEL:  cfg_nxt.turn_decel_step  = pwdata[REG_W-1:0];
        default:         cfg_nxt = cfg_r;  // drop writes past the map
      endcase
    end
  end

  always_comb begin
    unique case (idx)
      REG_DEADBAND:    prdata = APB_DW'(cfg_r.deadband);
      REG_SPEED_ACCEL: prdata = APB_DW'(cfg_r.speed_accel_step);
      REG_SPEED_DECEL: prdata = APB_DW'(cfg_r.speed_decel_step);
      REG_TURN_ACCEL:  prdata = APB_DW'(cfg_r.turn_accel_step);
      REG_TURN_DECEL:  prdata = APB_DW'(cfg_r.turn_decel_step);
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.deadband         <= DEADBAND_RST;
      cfg_r.speed_accel_step <= SPEED_ACCEL_RST;
      cfg_r.speed_decel_step <= SPEED_DECEL_RST;
      cfg_r.turn_accel_step  <= TURN_ACCEL_RST;
      cfg_r.turn_decel_step  <= TURN_DECEL_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/dsrl_channel.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// dsrl_channel
// One slew-limited channel: deadband snap, accel/decel step toward the
// saturated command, and the channel state register.
// ----------------------------------------------------------------------------
module dsrl_channel
  import dsrl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     load,
  input  wire logic                     enabled,
  input  wire logic signed [DATA_W-1:0] cmd,
  input  wire logic        [REG_W-1:0]  deadband,
  input  wire logic        [REG_W-1:0]  acc_step,
  input  wire logic        [REG_W-1:0]  dec_step,
  output logic signed      [DATA_W-1:0] now,
  output logic signed      [DATA_W-1:0] now_nxt
);

  logic signed [DATA_W-1:0] now_r;
  logic signed [CALC_W-1:0] cmd_s;
  logic signed [CALC_W-1:0] now_s;
  logic        [CALC_W-1:0] mag_cmd;
  logic        [CALC_W-1:0] mag_now;
  logic signed [CALC_W-1:0] step;
  logic signed [CALC_W-1:0] up;
  logic signed [CALC_W-1:0] dn;
  logic signed [CALC_W-1:0] moved;

  assign cmd_s   = sat_one(widen(cmd));
  assign now_s   = widen(now_r);
  assign mag_cmd = (cmd_s < 0) ? CALC_W'(-cmd_s) : CALC_W'(cmd_s);
  assign mag_now = (now_s < 0) ? CALC_W'(-now_s) : CALC_W'(now_s);
  assign step    = (mag_cmd > mag_now) ? CALC_W'(acc_step) : CALC_W'(dec_step);
  assign up      = now_s + step;
  assign dn      = now_s - step;

  always_comb begin
    // stop exactly at the command, never past it
    if (now_s < cmd_s) begin
      moved = (up > cmd_s) ? cmd_s : up;
    end else if (now_s > cmd_s) begin
      moved = (dn < cmd_s) ? cmd_s : dn;
    end else begin
      moved = now_s;
    end
  end

  always_comb begin
    if (!enabled || mag_cmd <= CALC_W'(deadband)) begin
      now_nxt = '0;
    end else begin
      now_nxt = moved[DATA_W-1:0];
    end
  end

  assign now = now_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      now_r <= '0;
    end else if (load) begin
      now_r <= now_nxt;
    end
  end

endmodule

`default_nettype wire

/* hw/rtl/drive_slew_rate_limiter_core.sv */
// Pipeline: an accepted input goes into the input register and then into the
//   result register, which raises out_valid; out_stall on a held result can
//   keep it in the input register. The channel update and mix sit between
//   the two registers.
// Throughput: one transaction per cycle while no held result stalls the output;
//   the add-compare-select of each channel closes the speed/turn state loop.
`default_nettype none
// ----------------------------------------------------------------------------
// drive_slew_rate_limiter_core
// Slew-rate limiter with deadband and arcade mix: two channel units, left and
// right drive mix with saturation, and a two-register valid/stall pipeline.
// Reset: synchronous, active low; clears both pipeline valids and the speed
// and turn state, and loads the register defaults.
// ----------------------------------------------------------------------------
module drive_slew_rate_limiter_core
  import dsrl_pkg::*;
(
  input  wire logic                     clk,
  input  wire logic                     rst_n,
  input  wire logic                     in_valid,
  output logic                          in_stall,
  input  wire logic                     in_enabled,
  input  wire logic signed [DATA_W-1:0] in_speed_cmd,
  input  wire logic signed [DATA_W-1:0] in_turn_cmd,
  output logic                          out_valid,
  input  wire logic                     out_stall,
  output logic signed      [DATA_W-1:0] out_left_drive,
  output logic signed      [DATA_W-1:0] out_right_drive,
  input  wire logic                     psel,
  input  wire logic                     penable,
  input  wire logic                     pwrite,
  input  wire logic        [APB_AW-1:0] paddr,
  input  wire logic        [APB_DW-1:0] pwdata,
  output logic             [APB_DW-1:0] prdata,
  output logic                          pready
);

  cfg_t cfg;

  logic                     s1_valid_r;
  logic                     s1_enabled_r;
  logic signed [DATA_W-1:0] s1_speed_r;
  logic signed [DATA_W-1:0] s1_turn_r;
  logic                     out_valid_r;
  logic signed [DATA_W-1:0] out_left_r;
  logic signed [DATA_W-1:0] out_right_r;

  logic                     out_free;
  logic                     s1_adv;
  logic signed [DATA_W-1:0] speed_now;
  logic signed [DATA_W-1:0] turn_now;
  logic signed [DATA_W-1:0] speed_nxt;
  logic signed [DATA_W-1:0] turn_nxt;
  logic signed [CALC_W-1:0] left_sum;
  logic signed [CALC_W-1:0] right_sum;
  logic signed [CALC_W-1:0] left_sat;
  logic signed [CALC_W-1:0] right_sat;

  dsrl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  assign out_free = !out_valid_r || !out_stall;
  assign s1_adv   = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  dsrl_channel u_speed (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_adv),
    .enabled  (s1_enabled_r),
    .cmd      (s1_speed_r),
    .deadband (cfg.deadband),
    .acc_step (cfg.speed_accel_step),
    .dec_step (cfg.speed_decel_step),
    .now      (speed_now),
    .now_nxt  (speed_nxt)
  );

  dsrl_channel u_turn (
    .clk      (clk),
    .rst_n    (rst_n),
    .load     (s1_adv),
    .enabled  (s1_enabled_r),
    .cmd      (s1_turn_r),
    .deadband (cfg.deadband),
    .acc_step (cfg.turn_accel_step),
    .dec_step (cfg.turn_decel_step),
    .now      (turn_now),
    .now_nxt  (turn_nxt)
  );

  // both channels are zero when disabled, so the mix gives zero drives
  assign left_sum  = widen(speed_nxt) + widen(turn_nxt);
  assign right_sum = widen(speed_nxt) - widen(turn_nxt);
  assign left_sat  = sat_one(left_sum);
  assign right_sat = sat_one(right_sum);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_enabled_r <= in_enabled;
      s1_speed_r   <= in_speed_cmd;
      s1_turn_r    <= in_turn_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_left_r  <= left_sat[DATA_W-1:0];
      out_right_r <= right_sat[DATA_W-1:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_left_drive  = out_left_r;
  assign out_right_drive = out_right_r;

`ifndef SYNTHESIS
  a_state_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    (widen(speed_now) <= ONE_Q) && (widen(speed_now) >= -ONE_Q) &&
    (widen(turn_now) <= ONE_Q) && (widen(turn_now) >= -ONE_Q))
    else $error("slew state outside plus or minus one");

  a_drive_in_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (widen(out_left_r) <= ONE_Q) && (widen(out_left_r) >= -ONE_Q) &&
                    (widen(out_right_r) <= ONE_Q) && (widen(out_right_r) >= -ONE_Q))
    else $error("drive outside plus or minus one");

  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> (s1_valid_r && out_valid_r && out_stall))
    else $error("input stalled without a blocked result");

  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !s1_adv |=> ($stable(speed_now) && $stable(turn_now)))
    else $error("state changed without a transaction");
`endif

endmodule

`default_nettype wire
